/* sv/assert_macros.svh */
// Assertion macros for the RTL of the frame bitmap allocator.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/fba_pkg.sv */
// Package of the frame bitmap allocator: sizes, constants and the
// command and status structs between controller and datapath. No dependencies.
package fba_pkg;

  localparam int FRAMES   = 1024;
  localparam int WORDS    = (FRAMES + 15) / 16;
  localparam int ADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FIDX_W   = ADDR_W + 4;
  localparam int RANGE_W  = 11;
  localparam int FNUM_W   = 10;
  localparam int CMP_W    = ((FIDX_W > RANGE_W) ? FIDX_W : RANGE_W) + 1;
  localparam int WORD_W   = 16;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);
  localparam logic [WORD_W-1:0] FIRST_BIT = 16'h8000;

  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_ALLOC = 1'b1;

  typedef struct packed {
    logic load_item;
    logic read_word;
    logic modify;
    logic advance;
    logic publish;
  } fba_cmd_t;

  typedef struct packed {
    logic kind_alloc;
    logic hit;
    logic last_word;
    logic out_busy;
  } fba_status_t;

endpackage

/* sv/frame_bitmap_allocator.sv */
// First-fit frame allocator over a free-frame bitmap of FRAMES bits held in a
// single-port memory of 16-bit words, cleared at reset. Each request is handled
// one at a time: the controller sweeps the words with a read-modify-write per
// word (a READ state, then a MODIFY state); a range request sweeps all WORDS words
// and an allocate request stops at the word holding the first free frame (or
// at the last word when none is free). A finished result sits in an output
// register, and the next request is accepted while it waits to be taken.
// Depends on fba_pkg, fba_ctrl, fba_datapath and assert_macros.svh.
`include "assert_macros.svh"

module frame_bitmap_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         kind,
  input  logic                         keep_others,
  input  logic [fba_pkg::RANGE_W-1:0]  start_frame,
  input  logic [fba_pkg::RANGE_W-1:0]  end_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [fba_pkg::FNUM_W-1:0]   frame_number
);
  import fba_pkg::*;

  fba_cmd_t    cmd;
  fba_status_t st;

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  fba_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .kind         (kind),
    .keep_others  (keep_others),
    .start_frame  (start_frame),
    .end_frame    (end_frame),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .frame_number (frame_number)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_NEXT(a_no_instant_result, clk, rst, in_valid && in_ready, !$rose(out_valid))
  `ASSERT_SAME(a_zero_when_not_found, clk, rst, out_valid && !found, frame_number == '0)

endmodule

/* sv/fba_ctrl.sv */
// Controller of the frame bitmap allocator: sequences the word-by-word
// read-modify-write sweep. Depends on fba_pkg.
module fba_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fba_pkg::fba_status_t st,
  output fba_pkg::fba_cmd_t    cmd
);
  import fba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_MODIFY = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   sweep_done;

  assign in_ready   = (state == S_IDLE);
  assign sweep_done = st.kind_alloc ? (st.hit || st.last_word) : st.last_word;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_READ;
        end
      end
      S_READ: begin
        cmd.read_word = 1'b1;
        state_next    = S_MODIFY;
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        if (sweep_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/fba_datapath.sv */
// Datapath of the frame bitmap allocator: bitmap memory with per-word valid
// bits, word counter, range mask, first-fit search and result register. Depends on fba_pkg.
module fba_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  fba_pkg::fba_cmd_t            cmd,
  output fba_pkg::fba_status_t         st,
  input  logic                         kind,
  input  logic                         keep_others,
  input  logic [fba_pkg::RANGE_W-1:0]  start_frame,
  input  logic [fba_pkg::RANGE_W-1:0]  end_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [fba_pkg::FNUM_W-1:0]   frame_number
);
  import fba_pkg::*;

  logic [WORD_W-1:0]  mem [WORDS];
  logic [WORDS-1:0]   vld;
  logic [WORD_W-1:0]  rdata;
  logic               rvalid;

  logic               kind_r;
  logic               keep_r;
  logic [RANGE_W-1:0] sf_r;
  logic [RANGE_W-1:0] ef_r;
  logic [ADDR_W-1:0]  addr;
  logic               found_r;
  logic [FNUM_W-1:0]  fnum_r;

  logic [WORD_W-1:0]  word_eff;
  logic [WORD_W-1:0]  range_mask;
  logic [WORD_W-1:0]  new_word;
  logic [3:0]         pos;
  logic [CMP_W-1:0]   fidx;
  logic [CMP_W-1:0]   hit_idx;
  logic               hit;
  logic               wr_en;

  assign word_eff = rvalid ? rdata : '0;
  assign hit      = |word_eff;

  always_comb begin
    range_mask = '0;
    fidx       = '0;
    for (int b = 0; b < WORD_W; b++) begin
      fidx = CMP_W'({addr, 4'(b)});
      range_mask[WORD_W-1-b] = (fidx >= CMP_W'(sf_r)) && (fidx < CMP_W'(ef_r)) &&
                               (fidx < CMP_W'(FRAMES));
    end
  end

  always_comb begin
    pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (word_eff[WORD_W-1-b]) begin
        pos = 4'(b);
      end
    end
  end

  assign hit_idx = CMP_W'({addr, pos});

  always_comb begin
    if (kind_r == KIND_ALLOC) begin
      new_word = word_eff & ~(FIRST_BIT >> pos);
      wr_en    = cmd.modify && hit;
    end else begin
      new_word = (keep_r ? word_eff : '0) | range_mask;
      wr_en    = cmd.modify;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= new_word;
    end
    if (cmd.read_word) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rvalid <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[addr] <= 1'b1;
      end
      if (cmd.read_word) begin
        rvalid <= vld[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r  <= kind;
      keep_r  <= keep_others;
      sf_r    <= start_frame;
      ef_r    <= end_frame;
      addr    <= '0;
      found_r <= 1'b0;
      fnum_r  <= '0;
    end else begin
      if (cmd.advance) begin
        addr <= addr + 1'b1;
      end
      if (cmd.modify && kind_r == KIND_ALLOC && hit) begin
        found_r <= 1'b1;
        fnum_r  <= hit_idx[FNUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      found        <= found_r;
      frame_number <= fnum_r;
    end
  end

  assign st.kind_alloc = (kind_r == KIND_ALLOC);
  assign st.hit        = hit;
  assign st.last_word  = (addr == LAST_ADDR);
  assign st.out_busy   = out_valid && !out_ready;

endmodule
